### hw/rtl/cpf_pkg.sv
`default_nettype none

package cpf_pkg;

	// Longest packet body the length field is clamped to
	localparam int unsigned MAX_BODY = 64;

	// Width that holds the largest length value (MAX_BODY + 2)
	localparam int unsigned LEN_W = $clog2(MAX_BODY + 3);

	localparam logic [7:0]  HEAD_HI    = 8'hEF;
	localparam logic [7:0]  HEAD_LO    = 8'h01;
	localparam logic [31:0] ADDR_RESET = 32'hFFFF_FFFF;

	// Byte positions within the serialized run of one packet
	localparam logic [3:0] POS_HEAD_HI = 4'd0;
	localparam logic [3:0] POS_HEAD_LO = 4'd1;
	localparam logic [3:0] POS_ADDR_3  = 4'd2;
	localparam logic [3:0] POS_ADDR_2  = 4'd3;
	localparam logic [3:0] POS_ADDR_1  = 4'd4;
	localparam logic [3:0] POS_ADDR_0  = 4'd5;
	localparam logic [3:0] POS_FLAG    = 4'd6;
	localparam logic [3:0] POS_LEN_HI  = 4'd7;
	localparam logic [3:0] POS_LEN_LO  = 4'd8;
	localparam logic [3:0] POS_BODY    = 4'd9;
	localparam logic [3:0] POS_SUM_HI  = 4'd10;
	localparam logic [3:0] POS_SUM_LO  = 4'd11;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       end_of_run;
		logic       end_of_packet;
	} beat_t;

endpackage

`default_nettype wire

### hw/rtl/command_packet_framer_core.sv
// Channel   Handshake            Payload
// input     in_valid / in_stall  body_byte, is_first, is_final, packet_flag, body_count
// output    out_valid/out_stall  tx_byte, end_of_run, end_of_packet
// config    cfg_wr_en            cfg_wr_data (device address)
//
// Each output transfer carries one byte; the byte selector emits one byte per cycle
// while the output register is free. A body byte inside a packet goes out alone, an
// opening byte after the header run, a closing byte before the checksum; the next item
// is taken in the cycle its predecessor's last byte moves into the output register.
// Reset (arst_n low) clears the open-packet flag, the checksum and both valid bits,
// and sets the device address to all ones.
// A stall on the output holds the output register and, once the selector is blocked,
// raises in_stall in the same cycle.
`default_nettype none

module command_packet_framer_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  body_byte,
	input  wire logic        is_first,
	input  wire logic        is_final,
	input  wire logic [7:0]  packet_flag,
	input  wire logic [6:0]  body_count,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       tx_byte,
	output logic             end_of_run,
	output logic             end_of_packet,
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data
);

	logic [31:0]    addr_q;
	logic           beat_valid;
	logic           beat_free;
	cpf_pkg::beat_t beat;
	cpf_pkg::beat_t out_beat;

	// Device address register; user must write it only while framer is idle (unchecked)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= cpf_pkg::ADDR_RESET;
		end else if (cfg_wr_en) begin
			addr_q <= cfg_wr_data;
		end
	end

	// Input register, byte position counter, checksum and byte selector
	cpf_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.body_byte   (body_byte),
		.is_first    (is_first),
		.is_final    (is_final),
		.packet_flag (packet_flag),
		.body_count  (body_count),
		.dev_addr    (addr_q),
		.beat_free   (beat_free),
		.beat_valid  (beat_valid),
		.beat        (beat)
	);

	// Output register: decouples the selector from receiver stalls
	cpf_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.beat_valid (beat_valid),
		.beat       (beat),
		.beat_free  (beat_free),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_beat   (out_beat)
	);

	assign tx_byte       = out_beat.tx_byte;
	assign end_of_run    = out_beat.end_of_run;
	assign end_of_packet = out_beat.end_of_packet;

`ifndef NO_ASSERTIONS
	// The checksum low byte always closes the run of its item
	a_eop_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_packet |-> end_of_run)
		else $error("end_of_packet without end_of_run");

	// An opening byte expands into a header run, so the input must block next cycle
	a_first_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && is_first |=> in_stall)
		else $error("input taken during header run");

	// A byte moved to the output register while the output is free must appear
	a_beat_lands: assert property (@(posedge clk) disable iff (!arst_n)
		beat_valid && beat_free |=> out_valid)
		else $error("selected byte lost before output register");
`endif

endmodule

`default_nettype wire

### hw/rtl/cpf_seq.sv
`default_nettype none

module cpf_seq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [7:0]          body_byte,
	input  wire logic                is_first,
	input  wire logic                is_final,
	input  wire logic [7:0]          packet_flag,
	input  wire logic [6:0]          body_count,
	input  wire logic [31:0]         dev_addr,
	input  wire logic                beat_free,
	output logic                     beat_valid,
	output cpf_pkg::beat_t           beat
);

	logic                        valid_s1;
	logic [7:0]                  byte_s1;
	logic                        final_s1;
	logic [7:0]                  flag_s1;
	logic [cpf_pkg::LEN_W-1:0]   len_s1;
	logic [3:0]                  pos_s1;
	logic [15:0]                 sum_q;
	logic                        in_packet_q;

	logic                        take;
	logic                        keep;
	logic                        adv;
	logic                        last;
	logic [7:0]                  byte_sel;
	logic                        summed;
	logic [15:0]                 cnt_ext;
	logic [15:0]                 cnt_clamp;
	logic [15:0]                 len_in;
	logic [15:0]                 len_out;

	// Clamp the body count and form the length field
	always_comb begin
		cnt_ext = 16'(body_count);
		priority if (cnt_ext == 16'd0) begin
			cnt_clamp = 16'd1;
		end else if (cnt_ext > 16'(cpf_pkg::MAX_BODY)) begin
			cnt_clamp = 16'(cpf_pkg::MAX_BODY);
		end else begin
			cnt_clamp = cnt_ext;
		end
		len_in = cnt_clamp + 16'd2;
	end

	assign take     = in_valid && !in_stall;
	assign keep     = is_first || in_packet_q;
	assign adv      = valid_s1 && beat_free;
	assign last     = final_s1 ? (pos_s1 == cpf_pkg::POS_SUM_LO) : (pos_s1 == cpf_pkg::POS_BODY);
	assign in_stall = valid_s1 && !(adv && last);
	assign len_out  = 16'(len_s1);

	always_comb begin
		summed = 1'b0;
		unique case (pos_s1)
			cpf_pkg::POS_HEAD_HI: byte_sel = cpf_pkg::HEAD_HI;
			cpf_pkg::POS_HEAD_LO: byte_sel = cpf_pkg::HEAD_LO;
			cpf_pkg::POS_ADDR_3:  byte_sel = dev_addr[31:24];
			cpf_pkg::POS_ADDR_2:  byte_sel = dev_addr[23:16];
			cpf_pkg::POS_ADDR_1:  byte_sel = dev_addr[15:8];
			cpf_pkg::POS_ADDR_0:  byte_sel = dev_addr[7:0];
			cpf_pkg::POS_FLAG: begin
				byte_sel = flag_s1;
				summed   = 1'b1;
			end
			cpf_pkg::POS_LEN_HI: begin
				byte_sel = len_out[15:8];
				summed   = 1'b1;
			end
			cpf_pkg::POS_LEN_LO: begin
				byte_sel = len_out[7:0];
				summed   = 1'b1;
			end
			cpf_pkg::POS_BODY: begin
				byte_sel = byte_s1;
				summed   = 1'b1;
			end
			cpf_pkg::POS_SUM_HI:  byte_sel = sum_q[15:8];
			cpf_pkg::POS_SUM_LO:  byte_sel = sum_q[7:0];
			default:              byte_sel = 8'h00;
		endcase
	end

	assign beat_valid         = adv;
	assign beat.tx_byte       = byte_sel;
	assign beat.end_of_run    = last;
	assign beat.end_of_packet = (pos_s1 == cpf_pkg::POS_SUM_LO);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			pos_s1      <= cpf_pkg::POS_HEAD_HI;
			sum_q       <= 16'd0;
			in_packet_q <= 1'b0;
		end else begin
			// Drop bytes that arrive outside a packet
			if (take && keep) begin
				valid_s1    <= 1'b1;
				pos_s1      <= is_first ? cpf_pkg::POS_HEAD_HI : cpf_pkg::POS_BODY;
				in_packet_q <= !is_final;
			end else if (adv) begin
				if (last) begin
					valid_s1 <= 1'b0;
				end else begin
					pos_s1 <= pos_s1 + 4'd1;
				end
			end
			if (adv) begin
				if (pos_s1 == cpf_pkg::POS_HEAD_HI || pos_s1 == cpf_pkg::POS_SUM_LO) begin
					sum_q <= 16'd0;
				end else if (summed) begin
					sum_q <= sum_q + 16'(byte_sel);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && keep) begin
			byte_s1  <= body_byte;
			final_s1 <= is_final;
			if (is_first) begin
				flag_s1 <= packet_flag;
				len_s1  <= len_in[cpf_pkg::LEN_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/cpf_out_reg.sv
`default_nettype none

module cpf_out_reg (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            beat_valid,
	input  wire cpf_pkg::beat_t  beat,
	output logic                 beat_free,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output cpf_pkg::beat_t       out_beat
);

	logic           out_valid_q;
	cpf_pkg::beat_t beat_s2;

	assign beat_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_beat  = beat_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (beat_free) begin
			out_valid_q <= beat_valid;
		end
	end

	// Hold the byte while the receiver stalls
	always_ff @(posedge clk) begin
		if (beat_free && beat_valid) begin
			beat_s2 <= beat;
		end
	end

endmodule

`default_nettype wire

### verif/command_packet_framer_core_test.sv
`timescale 1ns / 100ps

module command_packet_framer_core_test;

	// Longest stretch with no transfer on either channel before the run is declared hung
	localparam int unsigned QUIET_LIMIT = 2000;
	// Cycles to let pass after the last expected byte, before a register write or the end
	localparam int unsigned SETTLE_CYCLES = 16;
	// Length of the long receiver hold-off
	localparam int unsigned HOLD_CYCLES = 64;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  body_byte;
	logic        is_first;
	logic        is_final;
	logic [7:0]  packet_flag;
	logic [6:0]  body_count;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  tx_byte;
	logic        end_of_run;
	logic        end_of_packet;
	logic        cfg_wr_en;
	logic [31:0] cfg_wr_data;

	// Predictor state: the bench's own copy of address, checksum and open flag
	logic [31:0] dev_addr;
	logic [15:0] pkt_sum;
	logic        pkt_active;

	// Serial bytes still owed by the block, oldest first
	cpf_pkg::beat_t frame_bytes_due[$];

	// Sender-side view of the packet in progress (for counting and stimulus shaping)
	bit sender_open;
	int framed_items;

	int idle_pct;
	int stall_pct;
	int hold_asked;
	int hold_served;

	int errors;
	int in_transfers;
	int out_transfers;
	int packets_closed;
	int addr_writes;
	int quiet_cycles;

	command_packet_framer_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.body_byte     (body_byte),
		.is_first      (is_first),
		.is_final      (is_final),
		.packet_flag   (packet_flag),
		.body_count    (body_count),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.tx_byte       (tx_byte),
		.end_of_run    (end_of_run),
		.end_of_packet (end_of_packet),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Append one owed byte; fold it into the checksum when it is covered by the sum
	function automatic void queue_beat(input logic [7:0] value, input bit summed);
		cpf_pkg::beat_t b;
		b.tx_byte       = value;
		b.end_of_run    = 1'b0;
		b.end_of_packet = 1'b0;
		frame_bytes_due.push_back(b);
		if (summed)
			pkt_sum = pkt_sum + {8'h00, value};
	endfunction

	// Work out every serial byte that one accepted body transfer must produce
	function automatic void frame_body_byte(input logic [7:0] value, input logic first,
			input logic last, input logic [7:0] flag, input logic [6:0] count);
		logic [6:0]     clamped;
		logic [15:0]    len;
		cpf_pkg::beat_t tail;
		if (!first && !pkt_active)
			return;
		if (first) begin
			// Clamp the count before forming the length; the real byte count is not checked
			clamped = count;
			if (clamped == 7'd0)
				clamped = 7'd1;
			if (clamped > 7'(cpf_pkg::MAX_BODY))
				clamped = 7'(cpf_pkg::MAX_BODY);
			len = {9'd0, clamped} + 16'd2;
			// An open packet is dropped without a checksum
			pkt_sum    = 16'h0000;
			pkt_active = 1'b1;
			queue_beat(cpf_pkg::HEAD_HI, 1'b0);
			queue_beat(cpf_pkg::HEAD_LO, 1'b0);
			queue_beat(dev_addr[31:24], 1'b0);
			queue_beat(dev_addr[23:16], 1'b0);
			queue_beat(dev_addr[15:8], 1'b0);
			queue_beat(dev_addr[7:0], 1'b0);
			queue_beat(flag, 1'b1);
			queue_beat(len[15:8], 1'b1);
			queue_beat(len[7:0], 1'b1);
		end
		queue_beat(value, 1'b1);
		if (last) begin
			// Sum wraps at 16 bits; high byte first
			tail = '0;
			tail.tx_byte = pkt_sum[15:8];
			frame_bytes_due.push_back(tail);
			tail.tx_byte       = pkt_sum[7:0];
			tail.end_of_packet = 1'b1;
			frame_bytes_due.push_back(tail);
			pkt_active = 1'b0;
			pkt_sum    = 16'h0000;
		end
		tail = frame_bytes_due.pop_back();
		tail.end_of_run = 1'b1;
		frame_bytes_due.push_back(tail);
	endfunction

	// Predict on every accepted input transfer, sampling the pins before the edge settles
	always @(posedge clk) begin
		if (in_valid === 1'b1 && in_stall === 1'b0) begin
			in_transfers++;
			frame_body_byte(body_byte, is_first, is_final, packet_flag, body_count);
		end
	end

	// Compare every accepted output transfer with the oldest owed byte
	always @(posedge clk) begin : check_output
		cpf_pkg::beat_t want;
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			out_transfers++;
			if (end_of_packet === 1'b1)
				packets_closed++;
			if (frame_bytes_due.size() == 0) begin
				$error("unexpected output transfer: tx_byte %h", tx_byte);
				errors++;
			end else begin
				want = frame_bytes_due.pop_front();
				if (tx_byte !== want.tx_byte) begin
					$error("tx_byte: expected %h, got %h", want.tx_byte, tx_byte);
					errors++;
				end
				if (end_of_run !== want.end_of_run) begin
					$error("end_of_run: expected %b, got %b", want.end_of_run, end_of_run);
					errors++;
				end
				if (end_of_packet !== want.end_of_packet) begin
					$error("end_of_packet: expected %b, got %b", want.end_of_packet,
						end_of_packet);
					errors++;
				end
			end
		end
	end

	// End the run if nothing moves on either channel for too long
	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles", quiet_cycles);
			$display("Verification failed");
			$finish;
		end
	end

	// Receiver: stall at random, or hold off for a long stretch when asked
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asked != hold_served) begin
				hold_served++;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// Offer one body transfer, maybe after some idle cycles, and hold it until accepted
	task automatic send_item(input logic [7:0] value, input logic first, input logic last,
			input logic [7:0] flag, input logic [6:0] count);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		body_byte   <= value;
		is_first    <= first;
		is_final    <= last;
		packet_flag <= flag;
		body_count  <= count;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		// Track what the block does with it; stray bytes outside a packet are not counted
		if (first || sender_open) begin
			framed_items++;
			sender_open = !last;
		end
	endtask

	// Drop valid and wait until every owed byte has gone out, then let the block settle
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (frame_bytes_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the address register; the block must be idle
	task automatic write_device_address(input logic [31:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		dev_addr = value;
		addr_writes++;
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// One packet of n body bytes with random content; leave it open when close_it is 0
	task automatic send_packet(input int n, input bit close_it);
		logic [7:0] flag;
		logic [6:0] count;
		flag  = ($urandom_range(0, 9) < 7) ? 8'h01 : 8'($urandom);
		count = ($urandom_range(0, 9) < 6 && n <= cpf_pkg::MAX_BODY) ? 7'(n) :
			7'($urandom_range(0, 127));
		for (int i = 0; i < n; i++)
			send_item(8'($urandom), i == 0, close_it && i == n - 1,
				(i == 0) ? flag : 8'($urandom), (i == 0) ? count : 7'($urandom));
	endtask

	// Count clamps, single-byte packets, stray bytes and packets cut short by a new one
	task automatic test_directed_cases();
		idle_pct = 0;
		stall_pct <= 0;
		send_item(8'h00, 1'b1, 1'b1, 8'h00, 7'd0);
		send_item(8'hFF, 1'b1, 1'b1, 8'hFF, 7'd127);
		send_item(8'h5A, 1'b1, 1'b1, 8'h01, 7'd64);
		send_item(8'hA5, 1'b1, 1'b1, 8'h01, 7'd65);
		// Bytes while idle must vanish, final or not
		send_item(8'h33, 1'b0, 1'b0, 8'h01, 7'd1);
		send_item(8'hCC, 1'b0, 1'b1, 8'hFF, 7'd127);
		send_item(8'h01, 1'b1, 1'b0, 8'h01, 7'd3);
		send_item(8'hFF, 1'b0, 1'b0, 8'h00, 7'd0);
		send_item(8'h00, 1'b0, 1'b1, 8'hFF, 7'd127);
		// New packet while one is open
		send_item(8'h0D, 1'b1, 1'b0, 8'h01, 7'd4);
		send_item(8'h11, 1'b0, 1'b0, 8'h01, 7'd4);
		send_item(8'h22, 1'b1, 1'b0, 8'h07, 7'd2);
		send_item(8'h44, 1'b0, 1'b1, 8'h01, 7'd2);
		send_item(8'h77, 1'b1, 1'b0, 8'h01, 7'd2);
		send_item(8'h88, 1'b1, 1'b1, 8'h02, 7'd1);
		wait_drained();
	endtask

	// Address extremes and one random value
	task automatic test_address_extremes();
		logic [31:0] addr_set[3];
		addr_set[0] = 32'h0000_0000;
		addr_set[1] = 32'hFFFF_FFFF;
		addr_set[2] = $urandom;
		foreach (addr_set[k]) begin
			write_device_address(addr_set[k]);
			send_item(8'($urandom), 1'b1, 1'b1, 8'h01, 7'd1);
			send_packet(2, 1'b1);
			wait_drained();
		end
	endtask

	// A body long enough of all-ones bytes that the 16-bit sum wraps
	task automatic test_checksum_wrap();
		for (int i = 0; i < 258; i++)
			send_item(8'hFF, i == 0, i == 257, 8'hFF, 7'd64);
		wait_drained();
	endtask

	// Long receiver hold-off while the sender keeps offering, so the input stalls
	task automatic test_backpressure();
		idle_pct = 0;
		stall_pct <= 0;
		hold_asked <= hold_asked + 1;
		send_packet(16, 1'b1);
		wait_drained();
	endtask

	// Sender pauses mid-packet until every owed byte is out, then finishes the packet
	task automatic test_drain_pause();
		send_packet(3, 1'b0);
		wait_drained();
		send_item(8'($urandom), 1'b0, 1'b0, 8'h00, 7'd0);
		send_item(8'($urandom), 1'b0, 1'b1, 8'h00, 7'd0);
		wait_drained();
	endtask

	// Mostly well-formed packets of random content; some cut short, some stray bytes
	task automatic run_traffic_phase(input int send_idle, input int rx_stall, input int budget);
		int start;
		int pick;
		int n;
		idle_pct = send_idle;
		stall_pct <= rx_stall;
		start = framed_items;
		while (framed_items - start < budget) begin
			pick = $urandom_range(0, 99);
			n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 40);
			if (pick < 8 && !sender_open)
				send_item(8'($urandom), 1'b0, 1'($urandom), 8'($urandom), 7'($urandom));
			else if (pick < 20)
				send_packet(n, 1'b0);
			else
				send_packet(n, 1'b1);
		end
		// Close any open packet so the block is idle before the next address write
		if (sender_open)
			send_item(8'($urandom), 1'b0, 1'b1, 8'($urandom), 7'($urandom));
		wait_drained();
	endtask

	task automatic test_random_traffic();
		write_device_address($urandom);
		run_traffic_phase(0, 0, 8);
		write_device_address($urandom);
		run_traffic_phase(82, 0, 8);
		write_device_address($urandom);
		run_traffic_phase(0, 82, 8);
		write_device_address($urandom);
		run_traffic_phase(26, 26, 8);
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		body_byte   = 8'h00;
		is_first    = 1'b0;
		is_final    = 1'b0;
		packet_flag = 8'h00;
		body_count  = 7'd0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = 32'h0000_0000;
		dev_addr    = cpf_pkg::ADDR_RESET;
		pkt_sum     = 16'h0000;
		pkt_active  = 1'b0;
		sender_open = 1'b0;
		idle_pct    = 0;
		stall_pct   = 0;
		hold_asked  = 0;
		hold_served = 0;
		errors      = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_address_extremes();
		test_checksum_wrap();
		test_backpressure();
		test_drain_pause();
		test_random_traffic();

		wait_drained();
		$display("Run covered %0d input and %0d output transfers, %0d closed packets,",
			in_transfers, out_transfers, packets_closed);
		$display("%0d address writes, clamped counts, abandoned packets and a wrapped checksum",
			addr_writes);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
